### hdl/evtu_pkg.sv
// Shared types and constants for the eikonal voxel time update block.
// No dependencies; every other file in hdl/ imports this package.
package evtu_pkg;

    // Time word width; the fraction point does not change any datapath width.
    localparam int TW = 32;
    // Radicand width: up to three squared time words plus headroom.
    localparam int RW = 2 * TW + 2;
    // Square root result width and number of root stages.
    localparam int NS = TW + 1;
    // Width of the pre-divide total.
    localparam int ND = TW + 3;

    // Divide by three in two digits: reciprocal multiply on the high part,
    // then on the high remainder joined with the low part.
    localparam int DLO = 17;
    localparam int DHI = ND - DLO;
    localparam int DKH = DHI + 2;
    localparam int DKL = DLO + 4;
    localparam logic [DKH-1:0] DMH = DKH'((2 ** DKH + 2) / 3);
    localparam logic [DKL-1:0] DML = DKL'((2 ** DKL + 2) / 3);

    // Queue between the front and back parts.
    localparam int QDEPTH = 8;
    localparam int QAW    = 3;
    localparam int QCW    = 4;
    // Front stages that may hold items not yet in the queue, plus one arriving.
    localparam int QSLACK = 4;

    // How many axes carry at least one valid neighbour.
    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_ONE,
        CLS_TWO,
        CLS_THREE
    } cls_t;

    // Item handed from the front part to the back part.
    typedef struct packed {
        cls_t              cls;
        logic [TW:0]       one_sum;
        logic [TW+1:0]     sum;
        logic [TW-1:0]     top;
        logic [2*TW-1:0]   ss;
        logic [2*TW-1:0]   sq01;
        logic [2*TW-1:0]   sq02;
        logic [2*TW-1:0]   sq12;
    } work_t;

    // Fields that ride along the root and divide pipelines.
    typedef struct packed {
        cls_t              cls;
        logic [TW:0]       one_sum;
        logic [TW+1:0]     sum;
        logic [TW-1:0]     top;
        logic              ge;
    } side_t;

endpackage

### hdl/evtu_front.sv
// Front part: takes an item, picks per-axis minimum times, classifies the
// axis count and forms the squares. Depends on evtu_pkg.
module evtu_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_vld,
    input  logic [evtu_pkg::TW-1:0] x_minus_time,
    input  logic [evtu_pkg::TW-1:0] x_plus_time,
    input  logic [evtu_pkg::TW-1:0] y_minus_time,
    input  logic [evtu_pkg::TW-1:0] y_plus_time,
    input  logic [evtu_pkg::TW-1:0] z_minus_time,
    input  logic [evtu_pkg::TW-1:0] z_plus_time,
    input  logic [5:0]            neighbour_valid_mask,
    input  logic [evtu_pkg::TW-1:0] inverse_speed,
    output logic                  out_vld,
    output evtu_pkg::work_t       out_item
);
    import evtu_pkg::*;

    // Stage A: per-axis validity and minimum
    logic          a_vld_reg;
    logic [2:0]    a_av_reg;
    logic [TW-1:0] a_m0_reg, a_m1_reg, a_m2_reg, a_s_reg;

    // Stage B: compacted axes
    logic          b_vld_reg;
    cls_t          b_cls_reg;
    logic [TW:0]   b_one_reg;
    logic [TW+1:0] b_sum_reg;
    logic [TW-1:0] b_top_reg, b_s_reg, b_d01_reg, b_d02_reg, b_d12_reg;

    // Stage C: squares
    logic          c_vld_reg;
    work_t         c_item_reg;

    logic [TW-1:0] m0_next, m1_next, m2_next;
    logic [TW-1:0] ax0, ax1, ax2, top01;
    cls_t          cls_next;

    // Pick the smaller valid time per axis
    always_comb
    begin
        m0_next = x_minus_time;
        m1_next = y_minus_time;
        m2_next = z_minus_time;
        if (!neighbour_valid_mask[0] ||
            (neighbour_valid_mask[1] && x_plus_time < x_minus_time))
        begin
            m0_next = x_plus_time;
        end
        if (!neighbour_valid_mask[2] ||
            (neighbour_valid_mask[3] && y_plus_time < y_minus_time))
        begin
            m1_next = y_plus_time;
        end
        if (!neighbour_valid_mask[4] ||
            (neighbour_valid_mask[5] && z_plus_time < z_minus_time))
        begin
            m2_next = z_plus_time;
        end
    end

    // Compact the used axes to the low slots; unused slots read zero
    always_comb
    begin
        ax0      = '0;
        ax1      = '0;
        ax2      = '0;
        cls_next = CLS_NONE;
        case (a_av_reg)
            3'b001: begin ax0 = a_m0_reg; cls_next = CLS_ONE; end
            3'b010: begin ax0 = a_m1_reg; cls_next = CLS_ONE; end
            3'b100: begin ax0 = a_m2_reg; cls_next = CLS_ONE; end
            3'b011: begin ax0 = a_m0_reg; ax1 = a_m1_reg; cls_next = CLS_TWO; end
            3'b101: begin ax0 = a_m0_reg; ax1 = a_m2_reg; cls_next = CLS_TWO; end
            3'b110: begin ax0 = a_m1_reg; ax1 = a_m2_reg; cls_next = CLS_TWO; end
            3'b111:
            begin
                ax0 = a_m0_reg;
                ax1 = a_m1_reg;
                ax2 = a_m2_reg;
                cls_next = CLS_THREE;
            end
            default: cls_next = CLS_NONE;
        endcase
        top01 = (ax0 > ax1) ? ax0 : ax1;
    end

    // Advance valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= in_vld;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        a_av_reg <= {|neighbour_valid_mask[5:4], |neighbour_valid_mask[3:2],
                     |neighbour_valid_mask[1:0]};
        a_m0_reg <= m0_next;
        a_m1_reg <= m1_next;
        a_m2_reg <= m2_next;
        a_s_reg  <= inverse_speed;

        b_cls_reg <= cls_next;
        b_one_reg <= {1'b0, a_s_reg} + {1'b0, ax0};
        b_sum_reg <= {2'b00, ax0} + {2'b00, ax1} + {2'b00, ax2};
        b_top_reg <= (top01 > ax2) ? top01 : ax2;
        b_s_reg   <= a_s_reg;
        b_d01_reg <= (ax0 >= ax1) ? ax0 - ax1 : ax1 - ax0;
        b_d02_reg <= (ax0 >= ax2) ? ax0 - ax2 : ax2 - ax0;
        b_d12_reg <= (ax1 >= ax2) ? ax1 - ax2 : ax2 - ax1;

        c_item_reg.cls     <= b_cls_reg;
        c_item_reg.one_sum <= b_one_reg;
        c_item_reg.sum     <= b_sum_reg;
        c_item_reg.top     <= b_top_reg;
        c_item_reg.ss      <= b_s_reg * b_s_reg;
        c_item_reg.sq01    <= b_d01_reg * b_d01_reg;
        c_item_reg.sq02    <= b_d02_reg * b_d02_reg;
        c_item_reg.sq12    <= b_d12_reg * b_d12_reg;
    end

    assign out_vld  = c_vld_reg;
    assign out_item = c_item_reg;

endmodule

### hdl/evtu_queue.sv
// Short queue between the front and back parts of the block.
// Depends on evtu_pkg for the item type and depth.
module evtu_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  evtu_pkg::work_t din,
    output logic            out_vld,
    output evtu_pkg::work_t dout,
    output logic            full_soon
);
    import evtu_pkg::*;

    work_t             mem_reg [QDEPTH];
    logic [QAW-1:0]    wr_reg, rd_reg;
    logic [QCW-1:0]    cnt_reg, cnt_next;
    logic              pop;

    // The back part never stalls: drain whenever an item is held
    assign pop      = (cnt_reg != '0);
    assign out_vld  = pop;
    assign dout     = mem_reg[rd_reg];
    assign full_soon = (cnt_reg >= QCW'(QDEPTH - QSLACK));

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // Hold pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    // Store items
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= din;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (cnt_reg < QCW'(QDEPTH)))
        else $error("queue written while full");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCW'(QDEPTH))
        else $error("queue count out of range");

    a_idle_stays_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0 && !push) |=> (cnt_reg == '0))
        else $error("queue count moved without a write");

endmodule

### hdl/evtu_sqrt.sv
// Pipelined floor square root, one result bit per stage, with side fields.
// Depends on evtu_pkg for widths and the side type.
module evtu_sqrt (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_vld,
    input  logic [evtu_pkg::RW-1:0] rad,
    input  evtu_pkg::side_t        in_side,
    output logic                   out_vld,
    output logic [evtu_pkg::NS-1:0] root,
    output evtu_pkg::side_t        out_side
);
    import evtu_pkg::*;

    logic          vld_reg  [0:NS];
    logic [RW-1:0] rem_reg  [0:NS];
    logic [NS-1:0] root_reg [0:NS];
    side_t         side_reg [0:NS];

    // Load the first stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= rad;
        root_reg[0] <= '0;
        side_reg[0] <= in_side;
    end

    // One stage per root bit, most significant first
    genvar i;
    for (i = 0; i < NS; i++)
    begin : g_stage
        localparam int B = NS - 1 - i;
        logic [RW+1:0] trial;
        logic          fit;

        assign trial = ({{(RW + 2 - NS){1'b0}}, root_reg[i]} << (B + 1))
                     | ((RW + 2)'(1) << (2 * B));
        assign fit   = ({2'b00, rem_reg[i]} >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i+1]  <= fit ? rem_reg[i] - trial[RW-1:0] : rem_reg[i];
            root_reg[i+1] <= fit ? (root_reg[i] | (NS'(1) << B)) : root_reg[i];
            side_reg[i+1] <= side_reg[i];
        end
    end

    assign out_vld  = vld_reg[NS];
    assign root     = root_reg[NS];
    assign out_side = side_reg[NS];

endmodule

### hdl/evtu_back.sv
// Back part: discriminant, square root, divide by three, final select and
// saturation. Depends on evtu_pkg and evtu_sqrt.
module evtu_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_vld,
    input  evtu_pkg::work_t         in_item,
    output logic                    done,
    output logic [evtu_pkg::TW-1:0] new_time,
    output logic                    no_neighbour_error
);
    import evtu_pkg::*;

    // Discriminant terms
    logic          p_vld_reg;
    logic [RW-1:0] p_pos_reg, p_neg_reg;
    side_t         p_side_reg;
    side_t         p_side;
    logic [RW-1:0] rad;
    logic          ge;

    logic          sq_vld;
    logic [NS-1:0] sq_root;
    side_t         sq_side;
    logic [ND-1:0] total;

    // Divide-by-three stages: load, high digit, full quotient
    logic               d0_vld_reg, d1_vld_reg, d2_vld_reg;
    logic [ND-1:0]      d0_x_reg, d1_x_reg, d2_x_reg;
    logic [DHI-1:0]     d1_qh_reg;
    logic [ND-1:0]      d2_q_reg;
    side_t              d0_side_reg, d1_side_reg, d2_side_reg;
    logic [DHI+DKH-1:0] qh_prod;
    logic [1:0]         rh;
    logic [DLO+1:0]     y_low;
    logic [DLO+DKL+1:0] ql_prod;

    logic          out_vld_reg;
    logic [TW-1:0] out_time_reg;
    logic          out_err_reg;

    logic [TW-1:0] time_next;
    side_t         fin;
    logic [ND-1:0] half;

    function automatic logic [TW-1:0] sat_time(input logic [ND-1:0] v);
        logic [TW-1:0] r;
        r = (v[ND-1:TW] != '0) ? {TW{1'b1}} : v[TW-1:0];
        return r;
    endfunction

    // Form both sides of the discriminant
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg <= 1'b0;
        end
        else
        begin
            p_vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        p_pos_reg <= {1'b0, in_item.ss, 1'b0}
                   + ((in_item.cls == CLS_THREE) ? {2'b00, in_item.ss} : '0);
        p_neg_reg <= {2'b00, in_item.sq01}
                   + ((in_item.cls == CLS_THREE)
                      ? ({2'b00, in_item.sq02} + {2'b00, in_item.sq12}) : '0);
        p_side_reg.cls     <= in_item.cls;
        p_side_reg.one_sum <= in_item.one_sum;
        p_side_reg.sum     <= in_item.sum;
        p_side_reg.top     <= in_item.top;
        p_side_reg.ge      <= 1'b0;
    end

    // Compare and take the difference; a negative case roots zero
    always_comb
    begin
        ge        = (p_pos_reg >= p_neg_reg);
        rad       = ge ? p_pos_reg - p_neg_reg : '0;
        p_side    = p_side_reg;
        p_side.ge = ge;
    end

    evtu_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (p_vld_reg),
        .rad      (rad),
        .in_side  (p_side),
        .out_vld  (sq_vld),
        .root     (sq_root),
        .out_side (sq_side)
    );

    assign total = {1'b0, sq_side.sum} + {2'b00, sq_root};

    // High digit by reciprocal multiply; low digit from its remainder
    assign qh_prod = {{DKH{1'b0}}, d0_x_reg[ND-1:DLO]} * {{DHI{1'b0}}, DMH};
    assign rh      = d1_x_reg[DLO+1:DLO] - (d1_qh_reg[1:0] + {d1_qh_reg[0], 1'b0});
    assign y_low   = {rh, d1_x_reg[DLO-1:0]};
    assign ql_prod = {{DKL{1'b0}}, y_low} * {{(DLO + 2){1'b0}}, DML};

    // Advance divider valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d0_vld_reg <= 1'b0;
            d1_vld_reg <= 1'b0;
            d2_vld_reg <= 1'b0;
        end
        else
        begin
            d0_vld_reg <= sq_vld;
            d1_vld_reg <= d0_vld_reg;
            d2_vld_reg <= d1_vld_reg;
        end
    end

    // Advance divider payload
    always_ff @(posedge clk)
    begin
        d0_x_reg    <= total;
        d0_side_reg <= sq_side;

        d1_x_reg    <= d0_x_reg;
        d1_qh_reg   <= qh_prod[DHI+DKH-1:DKH];
        d1_side_reg <= d0_side_reg;

        d2_x_reg    <= d1_x_reg;
        d2_q_reg    <= {d1_qh_reg, ql_prod[DKL +: DLO]};
        d2_side_reg <= d1_side_reg;
    end

    // Select the result by axis count and saturate
    always_comb
    begin
        fin  = d2_side_reg;
        half = d2_x_reg >> 1;
        case (fin.cls)
            CLS_NONE:  time_next = '0;
            CLS_ONE:   time_next = sat_time({{(ND - TW - 1){1'b0}}, fin.one_sum});
            CLS_TWO:   time_next = fin.ge ? sat_time(half) : fin.top;
            CLS_THREE: time_next = fin.ge ? sat_time(d2_q_reg) : fin.top;
            default:   time_next = '0;
        endcase
    end

    // Register the result and its valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= d2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        out_time_reg <= time_next;
        out_err_reg  <= (fin.cls == CLS_NONE);
    end

    assign done               = out_vld_reg;
    assign new_time           = out_time_reg;
    assign no_neighbour_error = out_err_reg;

endmodule

### hdl/eikonal_voxel_time_update.sv
// Top level of the eikonal voxel time update block.
// Depends on evtu_pkg, evtu_front, evtu_queue and evtu_back.
//
// Usage:
//   Present six neighbour times, the valid mask and the inverse speed with
//   start high; the item is taken at a rising edge where busy is low.
//   One result per item appears on new_time / no_neighbour_error for
//   exactly one cycle, marked by done, in the order the items were taken.
// Throughput: one item per cycle, sustained while busy is low.
// Pipeline: from the accepting edge, an item passes 3 front stages, the queue
//   register, 1 discriminant stage, 34 square root stages (one per root bit
//   plus load), 3 divide-by-three stages (load plus two reciprocal-multiply
//   digits) and 1 output register.
//   The pipelined square root holds most of these stages.
// Reset: rst_n clears all valid flags and the queue; items in flight drop.
// The receiver cannot stall; done is a strobe and results are not held.
// busy rises only if the front-to-back queue comes close to full.
module eikonal_voxel_time_update (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [evtu_pkg::TW-1:0] x_minus_time,
    input  logic [evtu_pkg::TW-1:0] x_plus_time,
    input  logic [evtu_pkg::TW-1:0] y_minus_time,
    input  logic [evtu_pkg::TW-1:0] y_plus_time,
    input  logic [evtu_pkg::TW-1:0] z_minus_time,
    input  logic [evtu_pkg::TW-1:0] z_plus_time,
    input  logic [5:0]              neighbour_valid_mask,
    input  logic [evtu_pkg::TW-1:0] inverse_speed,
    output logic                    done,
    output logic [evtu_pkg::TW-1:0] new_time,
    output logic                    no_neighbour_error
);
    import evtu_pkg::*;

    logic  accept;
    logic  f_vld, q_vld;
    work_t f_item, q_item;

    assign accept = start && !busy;

    evtu_front u_front (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_vld               (accept),
        .x_minus_time         (x_minus_time),
        .x_plus_time          (x_plus_time),
        .y_minus_time         (y_minus_time),
        .y_plus_time          (y_plus_time),
        .z_minus_time         (z_minus_time),
        .z_plus_time          (z_plus_time),
        .neighbour_valid_mask (neighbour_valid_mask),
        .inverse_speed        (inverse_speed),
        .out_vld              (f_vld),
        .out_item             (f_item)
    );

    evtu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_vld),
        .din       (f_item),
        .out_vld   (q_vld),
        .dout      (q_item),
        .full_soon (busy)
    );

    evtu_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_vld             (q_vld),
        .in_item            (q_item),
        .done               (done),
        .new_time           (new_time),
        .no_neighbour_error (no_neighbour_error)
    );

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && no_neighbour_error) |-> (new_time == '0))
        else $error("error item carries a nonzero time");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("front-to-back queue backed up");

endmodule

### test/eikonal_voxel_time_update_tb.sv
// Testbench for eikonal_voxel_time_update: directed and random voxel items,
// checked against an in-bench integer predictor. Depends on evtu_pkg and the RTL.
`timescale 1ns / 100ps

module eikonal_voxel_time_update_tb;
    import evtu_pkg::*;

    localparam int LATENCY   = 43;
    localparam int MAX_CYC   = 400000;
    localparam logic [31:0] TMAX = 32'hFFFF_FFFF;

    // Neighbour slots in a voxel's time array, in mask bit order
    localparam int MSK_XM = 0;
    localparam int MSK_XP = 1;
    localparam int MSK_YM = 2;
    localparam int MSK_YP = 3;
    localparam int MSK_ZM = 4;
    localparam int MSK_ZP = 5;

    typedef struct {
        logic [31:0] t [6];
        logic [5:0]  mask;
        logic [31:0] speed;
    } voxel_t;

    typedef struct {
        logic [31:0] arrival;
        logic        orphan;
    } arrival_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] x_minus_time, x_plus_time, y_minus_time, y_plus_time;
    logic [31:0] z_minus_time, z_plus_time;
    logic [5:0]  neighbour_valid_mask;
    logic [31:0] inverse_speed;
    logic        done;
    logic [31:0] new_time;
    logic        no_neighbour_error;

    arrival_t arrivals_due[$];
    int       n_fail;
    int       cyc;

    eikonal_voxel_time_update i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .x_minus_time(x_minus_time), .x_plus_time(x_plus_time),
        .y_minus_time(y_minus_time), .y_plus_time(y_plus_time),
        .z_minus_time(z_minus_time), .z_plus_time(z_plus_time),
        .neighbour_valid_mask(neighbour_valid_mask),
        .inverse_speed(inverse_speed),
        .done(done), .new_time(new_time),
        .no_neighbour_error(no_neighbour_error)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Floor square root of a radicand below 2^68
    function automatic logic [35:0] floor_root(logic [67:0] v);
        logic [35:0] r;
        logic [35:0] c;
        r = '0;
        for (int b = 35; b >= 0; b--) begin
            c = r | (36'd1 << b);
            if ({36'd0, c} * {36'd0, c} <= {4'd0, v}) r = c;
        end
        return r;
    endfunction

    function automatic logic [67:0] sq_gap(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = (a >= b) ? a - b : b - a;
        return {36'd0, d} * {36'd0, d};
    endfunction

    // First-order eikonal update for one voxel
    function automatic arrival_t eikonal_arrival(voxel_t v);
        arrival_t    r;
        logic [31:0] ax [3];
        logic [67:0] ss, pos, neg;
        logic [35:0] sum, top, total;
        int          n;
        logic        lo, hi;
        n = 0;
        r.orphan = 1'b0;
        r.arrival = '0;
        for (int k = 0; k < 3; k++) begin
            lo = v.mask[2*k];
            hi = v.mask[2*k+1];
            if (lo || hi) begin
                if (lo && hi) ax[n] = (v.t[2*k] < v.t[2*k+1]) ? v.t[2*k] : v.t[2*k+1];
                else if (lo) ax[n] = v.t[2*k];
                else ax[n] = v.t[2*k+1];
                n++;
            end
        end
        if (n == 0) begin
            r.orphan = 1'b1;
            return r;
        end
        if (n == 1) begin
            total = {4'd0, v.speed} + {4'd0, ax[0]};
            r.arrival = (total > {4'd0, TMAX}) ? TMAX : total[31:0];
            return r;
        end
        ss = {36'd0, v.speed} * {36'd0, v.speed};
        pos = ss + ss;
        neg = sq_gap(ax[0], ax[1]);
        sum = {4'd0, ax[0]} + {4'd0, ax[1]};
        top = (ax[0] > ax[1]) ? {4'd0, ax[0]} : {4'd0, ax[1]};
        if (n == 3) begin
            pos = pos + ss;
            neg = neg + sq_gap(ax[0], ax[2]) + sq_gap(ax[1], ax[2]);
            sum = sum + {4'd0, ax[2]};
            if ({4'd0, ax[2]} > top) top = {4'd0, ax[2]};
        end
        if (pos >= neg) begin
            total = sum + floor_root(pos - neg);
            total = (n == 3) ? total / 3 : total >> 1;
            r.arrival = (total > {4'd0, TMAX}) ? TMAX : total[31:0];
        end else begin
            r.arrival = top[31:0];
        end
        return r;
    endfunction

    // Random gap: mostly none or short, a few long; drop start while idle
    task automatic idle_gap();
        int g;
        g = $urandom_range(0, 99);
        if (g < 55) g = 0;
        else if (g < 92) g = $urandom_range(1, 3);
        else g = $urandom_range(10, 60);
        if (g > 0) start <= 1'b0;
        repeat (g) @(negedge clk);
    endtask

    // Drive one item and hold it until accepted; start stays high after
    task automatic send_voxel(voxel_t v);
        start <= 1'b1;
        x_minus_time <= v.t[MSK_XM];
        x_plus_time  <= v.t[MSK_XP];
        y_minus_time <= v.t[MSK_YM];
        y_plus_time  <= v.t[MSK_YP];
        z_minus_time <= v.t[MSK_ZM];
        z_plus_time  <= v.t[MSK_ZP];
        neighbour_valid_mask <= v.mask;
        inverse_speed <= v.speed;
        do @(posedge clk); while (busy);
        arrivals_due.insert(arrivals_due.size(), eikonal_arrival(v));
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_time();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 255);
            2: return TMAX - $urandom_range(0, 255);
            default: return $urandom_range(0, 32'h00FF_FFFF);
        endcase
    endfunction

    function automatic voxel_t rand_voxel();
        voxel_t v;
        for (int k = 0; k < 6; k++) v.t[k] = rand_time();
        // Close times make real roots likely
        if ($urandom_range(0, 1)) begin
            for (int k = 1; k < 6; k++) v.t[k] = v.t[0] + $urandom_range(0, 32'h3_0000);
        end
        v.mask = $urandom_range(0, 63);
        v.speed = rand_time();
        return v;
    endfunction

    // Check each result strobe against the oldest expectation
    always @(posedge clk) begin
        arrival_t e;
        if (rst_n && done) begin
            if (arrivals_due.size() == 0) begin
                $display("%0t: unexpected result new_time=%h err=%b",
                         $time, new_time, no_neighbour_error);
                n_fail++;
            end else begin
                e = arrivals_due.pop_front();
                if (new_time !== e.arrival) begin
                    $display("%0t: new_time expected %h actual %h",
                             $time, e.arrival, new_time);
                    n_fail++;
                end
                if (no_neighbour_error !== e.orphan) begin
                    $display("%0t: no_neighbour_error expected %b actual %b",
                             $time, e.orphan, no_neighbour_error);
                    n_fail++;
                end
            end
        end
    end

    // Run watchdog
    always @(posedge clk) begin
        cyc++;
        if (cyc > MAX_CYC) begin
            $display("eikonal_voxel_time_update verification failed");
            $finish;
        end
    end

    // Extremes of every field, each axis count, and each special case
    task automatic test_directed();
        voxel_t v;
        for (int m = 0; m < 64; m += 9) begin
            for (int k = 0; k < 6; k++) v.t[k] = 32'h0001_0000 * (k + 1);
            v.mask = m[5:0];
            v.speed = 32'h0001_0000;
            send_voxel(v);
        end
        // All ones: saturation with one axis and with three axes
        foreach (v.t[k]) v.t[k] = TMAX;
        v.speed = TMAX;
        foreach (v.mask[i]) begin
            v.mask = 6'd1 << i;
            send_voxel(v);
        end
        v.mask = 6'h3F;
        send_voxel(v);
        // All zeros, with and without neighbours
        foreach (v.t[k]) v.t[k] = '0;
        v.speed = '0;
        v.mask = 6'h3F; send_voxel(v);
        v.mask = 6'h00; send_voxel(v);
        // Negative discriminant on two and three axes
        v.t = '{32'h0010_0000, 32'h0, 32'h0000_0000, 32'h0, 32'h0020_0000, 32'h0};
        v.speed = 32'h0000_0100;
        v.mask = 6'h05; send_voxel(v);
        v.mask = 6'h15; send_voxel(v);
        // Zero discriminant: gap equals s*sqrt(2)-free case, d^2 = 2 s^2 impossible;
        // use equal times with zero speed
        v.t = '{32'h0003_0000, 32'h0003_0000, 32'h0003_0000, 32'h0003_0000,
                32'h0003_0000, 32'h0003_0000};
        v.speed = '0;
        v.mask = 6'h3F; send_voxel(v);
        v.mask = 6'h0A; send_voxel(v);
        // Minimum picked from the upper neighbour on x and y
        v.t = '{TMAX, 32'h5, TMAX, 32'h7, 32'h9, TMAX};
        v.speed = 32'h0002_0000;
        v.mask = 6'h3F; send_voxel(v);
    endtask

    // Random items with random pacing, one drain pause midway
    task automatic test_random();
        for (int i = 0; i < 420; i++) begin
            if (i == 200) begin
                start <= 1'b0;
                wait (arrivals_due.size() == 0);
                @(negedge clk);
            end
            if (i % 50 > 10) idle_gap();
            send_voxel(rand_voxel());
        end
    endtask

    initial begin
        n_fail = 0;
        cyc = 0;
        rst_n = 1'b0;
        start = 1'b0;
        x_minus_time = '0; x_plus_time = '0; y_minus_time = '0;
        y_plus_time = '0; z_minus_time = '0; z_plus_time = '0;
        neighbour_valid_mask = '0;
        inverse_speed = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random();
        start <= 1'b0;
        wait (arrivals_due.size() == 0);
        repeat (LATENCY + 10) @(negedge clk);
        if (n_fail == 0 && arrivals_due.size() == 0)
            $display("eikonal_voxel_time_update verification clean");
        else
            $display("eikonal_voxel_time_update verification failed");
        $finish;
    end

endmodule

### filelist.f
hdl/evtu_pkg.sv
hdl/evtu_front.sv
hdl/evtu_queue.sv
hdl/evtu_sqrt.sv
hdl/evtu_back.sv
hdl/eikonal_voxel_time_update.sv
test/eikonal_voxel_time_update_tb.sv
